// File: rtl/bfs_conversion_path_finder_top_defines.svh
`ifndef BFS_CONVERSION_PATH_FINDER_TOP_DEFINES_SVH
`define BFS_CONVERSION_PATH_FINDER_TOP_DEFINES_SVH
// assertion helpers
`define BFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BFS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

// File: rtl/bfs_pkg.sv
package bfs_pkg;
  localparam int NodeCount = 256;
  localparam int EdgesPerNode = 16;
  localparam int MaxHops = 10;
  localparam int WorkerCount = 64;
  localparam int NodeW = 8;
  localparam int EdgeW = 4;
  localparam int WildW = 6;
  localparam int WorkerW = 6;

  typedef enum logic [1:0] {
    ReqClear = 2'd0,
    ReqEdge  = 2'd1,
    ReqWild  = 2'd2,
    ReqQuery = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEdgeFull = 3'd1,
    StWildFull = 3'd2,
    StNoPath   = 3'd3,
    StTooLong  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OpNone, OpInit, OpHeadRd, OpEdgeRd, OpWildRd, OpVisit, OpBackRd, OpBackStep
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [EdgeW:0]   eidx;
    logic [WildW:0]   widx;
  } cmd_t;

  typedef struct packed {
    logic [NodeW:0]   head;
    logic [NodeW:0]   tail;
    logic [NodeW-1:0] cur;
    logic [EdgeW:0]   ecnt;
    logic [WildW:0]   wcnt;
    logic             dst_vis;
    logic             back_done;
    logic [3:0]       hops;
  } stat_t;
endpackage

// File: rtl/bfs_conversion_path_finder_top.sv
// channel  | dir | tdata fields (low bit up)                     | tuser
// s_axis   | in  | from_node[7:0] to_node[15:8] worker_id[21:16] | req_type[1:0]
// m_axis   | out | status[2:0] hop_worker[8:3] hop_index[12:9]    | -
//          |     | hop_count[16:13]                              | tlast = last
// Loads and clear read the edge count in TRead, then update it in TBusy and register the result.
// A query initialises the queue, then for each dequeued node compares it with the destination
// and reads its edges and then its wildcards; once the destination is dequeued it back-traces
// the parent links, checking one candidate node per cycle while edges and wildcards are read.
// Results leave one per cycle from the output register; a stall holds it.
// Reset clears the edge count valid bits and wildcard count; memories are not cleared.
`include "bfs_conversion_path_finder_top_defines.svh"
module bfs_conversion_path_finder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // from_node, to_node, worker_id
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status, hop_worker, hop_index, hop_count
  output logic        m_axis_tlast
);
  typedef enum logic [3:0] {
    TIdle = 4'b0001,
    TRead = 4'b0010,
    TBusy = 4'b0100,
    TEmit = 4'b1000
  } top_e;

  top_e tstate_q;
  logic [7:0] from_q, to_q;
  logic [5:0] worker_q;
  bfs_pkg::req_e req_q;
  logic load, start, done, found;
  bfs_pkg::cmd_t cmd;
  bfs_pkg::stat_t stat;
  logic [2:0] load_status;
  logic [3:0] emit_q, count_q, rd_idx;
  logic [5:0] rd_worker;
  logic accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = tstate_q == TIdle && !m_axis_tvalid;
  assign load = tstate_q == TBusy && req_q != bfs_pkg::ReqQuery;
  assign start = load ? 1'b0 : (tstate_q == TBusy);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      from_q <= s_axis_tdata[7:0];
      to_q <= s_axis_tdata[15:8];
      worker_q <= s_axis_tdata[21:16];
      req_q <= bfs_pkg::req_e'(s_axis_tuser);
    end
  end

  bfs_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .src_i(from_q), .dst_i(to_q),
    .stat_i(stat), .cmd_o(cmd), .done_o(done), .found_o(found)
  );

  bfs_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .load_i(load), .req_i(req_q), .from_i(from_q),
    .to_i(to_q), .worker_i(worker_q), .cmd_i(cmd), .stat_o(stat),
    .load_status_o(load_status), .rd_idx_i(rd_idx), .rd_worker_o(rd_worker)
  );

  assign rd_idx = count_q - 4'd1 - emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q <= TIdle;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
      emit_q <= '0;
      count_q <= '0;
    end else begin
      unique case (tstate_q)
        TIdle: begin
          if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
          if (accept) begin
            tstate_q <= TRead;
          end
        end
        TRead: begin
          tstate_q <= TBusy;
        end
        TBusy: begin
          if (load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast <= 1'b1;
            m_axis_tdata <= {21'd0, load_status};
            tstate_q <= TIdle;
          end else if (done) begin
            if (!found) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tlast <= 1'b1;
              m_axis_tdata <= {21'd0, 3'(bfs_pkg::StNoPath)};
              tstate_q <= TIdle;
            end else if (stat.hops > 4'(bfs_pkg::MaxHops)) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tlast <= 1'b1;
              m_axis_tdata <= {21'd0, 3'(bfs_pkg::StTooLong)};
              tstate_q <= TIdle;
            end else if (stat.hops == 4'd0) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tlast <= 1'b1;
              m_axis_tdata <= '0;
              tstate_q <= TIdle;
            end else begin
              count_q <= stat.hops;
              emit_q <= '0;
              tstate_q <= TEmit;
            end
          end
        end
        TEmit: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {7'd0, count_q, emit_q, rd_worker, 3'(bfs_pkg::StOk)};
            m_axis_tlast <= (emit_q + 4'd1) == count_q;
            emit_q <= emit_q + 4'd1;
            if ((emit_q + 4'd1) == count_q) begin
              tstate_q <= TIdle;
            end
          end
        end
        default: tstate_q <= TIdle;
      endcase
    end
  end

  `BFS_ASSERT(a_ready_idle, s_axis_tready |-> tstate_q == TIdle, "ready outside idle")
  `BFS_ASSERT_NEXT(a_accept_busy, accept, tstate_q == TRead, "accept not followed by work")
  `BFS_ASSERT(a_emit_count, tstate_q == TEmit |-> count_q != 4'd0, "empty path emitted")
endmodule

// File: rtl/bfs_ctrl.sv
module bfs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bfs_pkg::NodeW-1:0] src_i,
  input  logic [bfs_pkg::NodeW-1:0] dst_i,
  input  bfs_pkg::stat_t            stat_i,
  output bfs_pkg::cmd_t             cmd_o,
  output logic                      done_o,
  output logic                      found_o
);
  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SInit  = 8'b00000010,
    SHead  = 8'b00000100,
    SCheck = 8'b00001000,
    SEdge  = 8'b00010000,
    SWild  = 8'b00100000,
    SBack  = 8'b01000000,
    SStep  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [bfs_pkg::EdgeW:0] eidx_q, eidx_d;
  logic [bfs_pkg::WildW:0] widx_q, widx_d;
  logic done_d, found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      eidx_q <= '0;
      widx_q <= '0;
    end else begin
      state_q <= state_d;
      eidx_q <= eidx_d;
      widx_q <= widx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    eidx_d = eidx_q;
    widx_d = widx_q;
    cmd_o = '{op: bfs_pkg::OpNone, eidx: eidx_q, widx: widx_q};
    done_d = 1'b0;
    found_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SInit;
        end
      end
      SInit: begin
        cmd_o.op = bfs_pkg::OpInit;
        state_d = SHead;
      end
      SHead: begin
        if (stat_i.head == stat_i.tail) begin
          done_d = 1'b1;
          found_d = 1'b0;
          state_d = SIdle;
        end else begin
          cmd_o.op = bfs_pkg::OpHeadRd;
          state_d = SCheck;
        end
      end
      SCheck: begin
        eidx_d = '0;
        widx_d = '0;
        if (stat_i.cur == dst_i) begin
          state_d = SBack;
        end else begin
          state_d = SEdge;
        end
      end
      SEdge: begin
        if (eidx_q >= stat_i.ecnt) begin
          state_d = SWild;
        end else begin
          cmd_o.op = bfs_pkg::OpEdgeRd;
          eidx_d = eidx_q + 1'b1;
        end
      end
      SWild: begin
        if (widx_q >= stat_i.wcnt) begin
          cmd_o.op = bfs_pkg::OpVisit;
          state_d = SHead;
        end else begin
          cmd_o.op = bfs_pkg::OpWildRd;
          widx_d = widx_q + 1'b1;
        end
      end
      SBack: begin
        if (stat_i.back_done) begin
          done_d = 1'b1;
          found_d = 1'b1;
          state_d = SIdle;
        end else begin
          cmd_o.op = bfs_pkg::OpBackRd;
          state_d = SStep;
        end
      end
      SStep: begin
        cmd_o.op = bfs_pkg::OpBackStep;
        state_d = SBack;
      end
      default: state_d = SIdle;
    endcase
  end

  assign done_o = done_d;
  assign found_o = found_d;
  logic unused_src;
  assign unused_src = ^src_i;
endmodule

// File: rtl/bfs_datapath.sv
module bfs_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  bfs_pkg::req_e                   req_i,
  input  logic [bfs_pkg::NodeW-1:0]       from_i,
  input  logic [bfs_pkg::NodeW-1:0]       to_i,
  input  logic [bfs_pkg::WorkerW-1:0]     worker_i,
  input  bfs_pkg::cmd_t                   cmd_i,
  output bfs_pkg::stat_t                  stat_o,
  output logic [2:0]                      load_status_o,
  input  logic [3:0]                      rd_idx_i,
  output logic [bfs_pkg::WorkerW-1:0]     rd_worker_o
);
  localparam int NW = bfs_pkg::NodeW;
  localparam int EW = bfs_pkg::EdgeW;
  localparam int WW = bfs_pkg::WildW;
  localparam int KW = bfs_pkg::WorkerW;
  localparam int NC = bfs_pkg::NodeCount;

  logic [NW+KW-1:0] adj_mem [NC*bfs_pkg::EdgesPerNode];
  logic [NW+KW-1:0] wild_mem [bfs_pkg::WorkerCount];
  logic [EW:0]      ecnt_mem [NC];
  logic [NW-1:0]    queue_mem [NC];
  logic [NW+KW-1:0] par_mem [NC];
  logic [NC-1:0]    vis_q;
  logic [NC-1:0]    ecnt_vld_q;
  logic [WW:0]      wcnt_q;
  logic [KW-1:0]    path_q [bfs_pkg::MaxHops];
  logic [NW:0]      head_q, tail_q;
  logic [NW-1:0]    cur_q, back_q, src_q;
  logic [3:0]       hops_q;
  logic [EW:0]      ecnt_ld_raw_q, ecnt_cur_raw_q;
  logic             ecnt_ld_v_q, ecnt_cur_v_q;
  logic             cand_v_q;
  logic [NW+KW-1:0] cand_q, adj_rd_q, wild_rd_q, par_rd_q;
  logic             cand_from_adj_q, cand_from_wild_q;
  logic [NW+KW-1:0] cand;
  logic             cand_v;
  logic [EW:0]      ecnt_rd;
  logic             ecnt_wr;

  assign ecnt_rd = ecnt_ld_v_q ? ecnt_ld_raw_q : '0;
  assign ecnt_wr = load_i && req_i == bfs_pkg::ReqEdge &&
                   ecnt_rd < (EW+1)'(bfs_pkg::EdgesPerNode);

  always_ff @(posedge clk_i) begin
    if (ecnt_wr) begin
      adj_mem[{from_i, ecnt_rd[EW-1:0]}] <= {to_i, worker_i};
      ecnt_mem[from_i] <= ecnt_rd + 1'b1;
    end
    if (load_i && req_i == bfs_pkg::ReqWild && wcnt_q < (WW+1)'(bfs_pkg::WorkerCount)) begin
      wild_mem[wcnt_q[WW-1:0]] <= {to_i, worker_i};
    end
    adj_rd_q <= adj_mem[{cur_q, cmd_i.eidx[EW-1:0]}];
    wild_rd_q <= wild_mem[cmd_i.widx[WW-1:0]];
    par_rd_q <= par_mem[back_q];
    ecnt_ld_raw_q <= ecnt_mem[from_i];
    ecnt_cur_raw_q <= ecnt_mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_vld_q <= '0;
      ecnt_ld_v_q <= 1'b0;
      ecnt_cur_v_q <= 1'b0;
    end else begin
      if (load_i && req_i == bfs_pkg::ReqClear) begin
        ecnt_vld_q <= '0;
      end else if (ecnt_wr) begin
        ecnt_vld_q[from_i] <= 1'b1;
      end
      ecnt_ld_v_q <= ecnt_vld_q[from_i];
      ecnt_cur_v_q <= ecnt_vld_q[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
    end else if (load_i && req_i == bfs_pkg::ReqClear) begin
      wcnt_q <= '0;
    end else if (load_i && req_i == bfs_pkg::ReqWild && wcnt_q < (WW+1)'(bfs_pkg::WorkerCount)) begin
      wcnt_q <= wcnt_q + 1'b1;
    end
  end

  always_comb begin
    load_status_o = bfs_pkg::StOk;
    if (req_i == bfs_pkg::ReqEdge && ecnt_rd >= (EW+1)'(bfs_pkg::EdgesPerNode)) begin
      load_status_o = bfs_pkg::StEdgeFull;
    end else if (req_i == bfs_pkg::ReqWild && wcnt_q >= (WW+1)'(bfs_pkg::WorkerCount)) begin
      load_status_o = bfs_pkg::StWildFull;
    end
  end

  assign cand = cand_from_adj_q ? adj_rd_q : wild_rd_q;
  assign cand_v = cand_from_adj_q || cand_from_wild_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bfs_pkg::OpInit) begin
      queue_mem[0] <= from_i;
      par_mem[from_i] <= {from_i, {KW{1'b0}}};
      src_q <= from_i;
      back_q <= to_i;
    end
    if (cand_v && !vis_q[cand[NW+KW-1:KW]] && tail_q < (NW+1)'(NC)) begin
      queue_mem[tail_q[NW-1:0]] <= cand[NW+KW-1:KW];
      par_mem[cand[NW+KW-1:KW]] <= {cur_q, cand[KW-1:0]};
    end
    if (cmd_i.op == bfs_pkg::OpHeadRd) begin
      cur_q <= queue_mem[head_q[NW-1:0]];
    end
    if (cmd_i.op == bfs_pkg::OpBackStep) begin
      if (hops_q < 4'(bfs_pkg::MaxHops)) begin
        path_q[hops_q] <= par_rd_q[KW-1:0];
      end
      back_q <= par_rd_q[NW+KW-1:KW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      hops_q <= '0;
      cand_from_adj_q <= 1'b0;
      cand_from_wild_q <= 1'b0;
    end else begin
      cand_from_adj_q <= cmd_i.op == bfs_pkg::OpEdgeRd;
      cand_from_wild_q <= cmd_i.op == bfs_pkg::OpWildRd;
      if (cmd_i.op == bfs_pkg::OpInit) begin
        vis_q <= NC'(1) << from_i;
        head_q <= '0;
        tail_q <= (NW+1)'(1);
        hops_q <= '0;
      end else begin
        if (cand_v && !vis_q[cand[NW+KW-1:KW]] && tail_q < (NW+1)'(NC)) begin
          vis_q[cand[NW+KW-1:KW]] <= 1'b1;
          tail_q <= tail_q + 1'b1;
        end
        if (cmd_i.op == bfs_pkg::OpHeadRd) begin
          head_q <= head_q + 1'b1;
        end
        if (cmd_i.op == bfs_pkg::OpBackStep) begin
          hops_q <= hops_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.head = head_q;
  assign stat_o.tail = tail_q;
  assign stat_o.cur = cur_q;
  assign stat_o.ecnt = ecnt_cur_v_q ? ecnt_cur_raw_q : '0;
  assign stat_o.wcnt = wcnt_q;
  assign stat_o.dst_vis = 1'b1;
  assign stat_o.back_done = (back_q == src_q) || (hops_q > 4'(bfs_pkg::MaxHops));
  assign stat_o.hops = hops_q;
  assign rd_worker_o = path_q[rd_idx_i];
  logic unused_q;
  assign unused_q = ^cand_q ^ cand_v_q;
  always_ff @(posedge clk_i) begin
    cand_q <= cand;
    cand_v_q <= cand_v;
  end
endmodule
